[rtl/wmjm_pkg.sv]
// Shared types and codes of the word memory jump machine.
package wmjm_pkg;

    // Host request codes
    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_READ    = 2'd1,
        REQ_EXEC    = 2'd2,
        REQ_RESTART = 2'd3
    } t_req;

    // Executed instruction kinds; the opcode values match the kind codes
    typedef enum logic [2:0] {
        K_HLT  = 3'd0,
        K_JMP  = 3'd1,
        K_RVP  = 3'd2,
        K_WVP  = 3'd3,
        K_JE   = 3'd4,
        K_JNE  = 3'd5,
        K_NONE = 3'd6
    } t_kind;

    // Memory address source
    typedef enum logic [2:0] {
        ADDR_IP  = 3'd0,
        ADDR_IP1 = 3'd1,
        ADDR_IP2 = 3'd2,
        ADDR_IP3 = 3'd3,
        ADDR_MOD = 3'd4,
        ADDR_CLR = 3'd5
    } t_addr_sel;

    // Memory write data source
    typedef enum logic [1:0] {
        WD_ZERO  = 2'd0,
        WD_HOST  = 2'd1,
        WD_A2    = 2'd2,
        WD_RDATA = 2'd3
    } t_wd_sel;

    // Instruction pointer update
    typedef enum logic [1:0] {
        IP_HOLD  = 2'd0,
        IP_PLUS3 = 2'd1,
        IP_PLUS4 = 2'd2,
        IP_MOD   = 2'd3
    } t_ip_sel;

    // Operand of the address reduction unit
    typedef enum logic [2:0] {
        MS_HADDR = 3'd0,
        MS_START = 3'd1,
        MS_A1    = 3'd2,
        MS_A2    = 3'd3,
        MS_RDATA = 3'd4
    } t_mod_sel;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      accept;
        logic      clear;
        logic      mem_re;
        logic      mem_we;
        t_addr_sel addr_sel;
        t_wd_sel   wd_sel;
        t_ip_sel   ip_sel;
        logic      set_halt;
        logic      clr_halt;
        logic      latch_kind;
        logic      latch_a1;
        logic      latch_a2;
        logic      mod_start;
        t_mod_sel  mod_sel;
        logic      finish;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic  halted;
        t_kind kind;
        logic  take;
        logic  clr_last;
        logic  mod_done;
    } t_stat;

endpackage

[rtl/wmjm_rem.sv]
// Address reduction unit: remainder of a 64-bit word by the memory depth.
module wmjm_rem import wmjm_pkg::*; #(
    parameter int MEM_DEPTH = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [63:0]                  i_value,
    output logic                         o_done,
    output logic [$clog2(MEM_DEPTH)-1:0] o_res
);

    localparam int AW   = $clog2(MEM_DEPTH);
    localparam int RW   = AW + 1;
    localparam bit POW2 = ((MEM_DEPTH & (MEM_DEPTH - 1)) == 0);

    generate
        if (POW2) begin : g_mask
            logic [AW-1:0] r_res;
            logic          r_done;

            // Keep the low bits; done follows in the cycle after the start
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_res <= i_value[AW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_res  = r_res;
        end else begin : g_serial
            localparam int STEP  = 4;
            localparam int NSTEP = 64 / STEP;
            localparam int CW    = $clog2(NSTEP + 1);
            localparam logic [RW-1:0] DEPTH_W = RW'(MEM_DEPTH);

            logic [63:0]   r_val;
            logic [RW-1:0] r_rem;
            logic [RW-1:0] n_rem;
            logic [CW-1:0] r_cnt;
            logic          r_run;
            logic          r_done;

            // Shift in four bits MSB first, subtracting the depth after each where it fits
            always_comb begin
                logic [RW-1:0] t;
                t = r_rem;
                for (int i = 0; i < STEP; i++) begin
                    t = {t[RW-2:0], r_val[63-i]};
                    if (t >= DEPTH_W) begin
                        t = t - DEPTH_W;
                    end
                end
                n_rem = t;
            end

            // Step count and completion
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_run <= 1'b1;
                        r_cnt <= CW'(NSTEP);
                    end else if (r_run) begin
                        r_cnt <= r_cnt - CW'(1);
                        if (r_cnt == CW'(1)) begin
                            r_run  <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
            end

            // Operand and partial remainder
            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_val <= i_value;
                    r_rem <= '0;
                end else if (r_run) begin
                    r_val <= r_val << STEP;
                    r_rem <= n_rem;
                end
            end

            assign o_done = r_done;
            assign o_res  = r_rem[AW-1:0];
        end
    endgenerate

endmodule

[rtl/wmjm_dp.sv]
// Datapath: word memory, pointer, operand registers and result registers.
module wmjm_dp import wmjm_pkg::*; #(
    parameter int MEM_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [1:0]  i_req_type,
    input  logic [11:0] i_word_address,
    input  logic [63:0] i_word_value,
    input  logic        i_cfg_valid,
    input  logic [11:0] i_cfg_data,
    output logic [63:0] o_read_value,
    output logic [11:0] o_pointer_after,
    output logic        o_is_halted,
    output logic [2:0]  o_executed_kind,
    output logic        o_done
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int RW = AW + 1;
    localparam logic [RW-1:0] DEPTH_W = RW'(MEM_DEPTH);

    logic [63:0]   mem [MEM_DEPTH];
    logic [63:0]   r_rdata;
    logic [AW-1:0] mem_addr;
    logic [63:0]   wdata;

    logic [AW-1:0] r_ip;
    logic [AW-1:0] n_ip;
    logic          r_halt;
    logic [11:0]   r_start;
    logic [AW-1:0] r_clr_addr;
    t_req          r_req;
    t_kind         r_kind;
    t_kind         dec_kind;
    logic [63:0]   r_hval;
    logic [63:0]   r_a1;
    logic [63:0]   r_a2;

    logic [63:0]   mod_value;
    logic          mod_done;
    logic [AW-1:0] mod_res;

    logic [63:0]   r_read_value;
    logic [11:0]   r_pointer_after;
    logic          r_is_halted;
    logic [2:0]    r_executed_kind;
    logic          r_done;

    // Pointer plus a small step, wrapped at the depth
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [2:0] inc);
        logic [RW-1:0] s;
        s = {1'b0, base} + RW'(inc);
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    // Select the memory address
    always_comb begin
        unique case (i_cmd.addr_sel)
            ADDR_IP:  mem_addr = r_ip;
            ADDR_IP1: mem_addr = wrap_add(r_ip, 3'd1);
            ADDR_IP2: mem_addr = wrap_add(r_ip, 3'd2);
            ADDR_IP3: mem_addr = wrap_add(r_ip, 3'd3);
            ADDR_MOD: mem_addr = mod_res;
            ADDR_CLR: mem_addr = r_clr_addr;
            default:  mem_addr = r_ip;
        endcase
    end

    // Select the memory write data
    always_comb begin
        unique case (i_cmd.wd_sel)
            WD_ZERO:  wdata = '0;
            WD_HOST:  wdata = r_hval;
            WD_A2:    wdata = r_a2;
            WD_RDATA: wdata = r_rdata;
            default:  wdata = '0;
        endcase
    end

    // Single-port word memory with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem[mem_addr] <= wdata;
        end
        if (i_cmd.mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    // Select the word to reduce
    always_comb begin
        unique case (i_cmd.mod_sel)
            MS_HADDR: mod_value = 64'(i_word_address);
            MS_START: mod_value = 64'(r_start);
            MS_A1:    mod_value = r_a1;
            MS_A2:    mod_value = r_a2;
            MS_RDATA: mod_value = r_rdata;
            default:  mod_value = r_a1;
        endcase
    end

    wmjm_rem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mod_start),
        .i_value (mod_value),
        .o_done  (mod_done),
        .o_res   (mod_res)
    );

    // Next pointer
    always_comb begin
        unique case (i_cmd.ip_sel)
            IP_HOLD:  n_ip = r_ip;
            IP_PLUS3: n_ip = wrap_add(r_ip, 3'd3);
            IP_PLUS4: n_ip = wrap_add(r_ip, 3'd4);
            IP_MOD:   n_ip = mod_res;
            default:  n_ip = r_ip;
        endcase
    end

    // Decode the opcode word; unknown values halt
    always_comb begin
        if (r_rdata <= 64'(K_JNE)) begin
            dec_kind = t_kind'(r_rdata[2:0]);
        end else begin
            dec_kind = K_HLT;
        end
    end

    // Machine state, start address and clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip       <= '0;
            r_halt     <= 1'b0;
            r_start    <= '0;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            r_ip   <= n_ip;
            r_done <= i_cmd.finish;
            if (i_cfg_valid) begin
                r_start <= i_cfg_data;
            end
            if (i_cmd.set_halt) begin
                r_halt <= 1'b1;
            end else if (i_cmd.clr_halt) begin
                r_halt <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // Request fields and operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req  <= t_req'(i_req_type);
            r_hval <= i_word_value;
        end
        if (i_cmd.accept) begin
            r_kind <= K_NONE;
        end else if (i_cmd.latch_kind) begin
            r_kind <= dec_kind;
        end
        if (i_cmd.latch_a1) begin
            r_a1 <= r_rdata;
        end
        if (i_cmd.latch_a2) begin
            r_a2 <= r_rdata;
        end
    end

    // Capture the result item
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_read_value    <= (r_req == REQ_READ) ? r_rdata : 64'd0;
            r_pointer_after <= 12'(r_ip);
            r_is_halted     <= r_halt;
            r_executed_kind <= r_kind;
        end
    end

    assign o_stat.halted   = r_halt;
    assign o_stat.kind     = r_kind;
    assign o_stat.take     = ((r_a1 == r_a2) == (r_kind == K_JE));
    assign o_stat.clr_last = (r_clr_addr == AW'(MEM_DEPTH - 1));
    assign o_stat.mod_done = mod_done;

    assign o_read_value    = r_read_value;
    assign o_pointer_after = r_pointer_after;
    assign o_is_halted     = r_is_halted;
    assign o_executed_kind = r_executed_kind;
    assign o_done          = r_done;

endmodule

[rtl/wmjm_ctrl.sv]
// Controller: sequences memory accesses and address reductions per request.
module wmjm_ctrl import wmjm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_req_type,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       busy
);

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_CLEAR   = 17'h00002,
        S_RD_OP   = 17'h00004,
        S_RD_A1   = 17'h00008,
        S_RD_A2   = 17'h00010,
        S_DEC     = 17'h00020,
        S_EXEC    = 17'h00040,
        S_TGT     = 17'h00080,
        S_MOD     = 17'h00100,
        S_SETIP   = 17'h00200,
        S_RVP_RD  = 17'h00400,
        S_RVP_WR  = 17'h00800,
        S_WVP_WR  = 17'h01000,
        S_HWR     = 17'h02000,
        S_HRD     = 17'h04000,
        S_RESTART = 17'h08000,
        S_FIN     = 17'h10000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state r_ret;
    t_state n_ret;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear    = 1'b1;
                o_cmd.mem_we   = 1'b1;
                o_cmd.addr_sel = ADDR_CLR;
                o_cmd.wd_sel   = WD_ZERO;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    unique case (t_req'(i_req_type))
                        REQ_WRITE: begin
                            o_cmd.mod_start = 1'b1;
                            o_cmd.mod_sel   = MS_HADDR;
                            n_ret           = S_HWR;
                            n_state         = S_MOD;
                        end
                        REQ_READ: begin
                            o_cmd.mod_start = 1'b1;
                            o_cmd.mod_sel   = MS_HADDR;
                            n_ret           = S_HRD;
                            n_state         = S_MOD;
                        end
                        REQ_EXEC: begin
                            n_state = i_stat.halted ? S_FIN : S_RD_OP;
                        end
                        REQ_RESTART: begin
                            o_cmd.mod_start = 1'b1;
                            o_cmd.mod_sel   = MS_START;
                            n_ret           = S_RESTART;
                            n_state         = S_MOD;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            // Fetch opcode and the two operand words
            S_RD_OP: begin
                o_cmd.mem_re   = 1'b1;
                o_cmd.addr_sel = ADDR_IP;
                n_state        = S_RD_A1;
            end
            S_RD_A1: begin
                o_cmd.latch_kind = 1'b1;
                o_cmd.mem_re     = 1'b1;
                o_cmd.addr_sel   = ADDR_IP1;
                n_state          = S_RD_A2;
            end
            S_RD_A2: begin
                o_cmd.latch_a1 = 1'b1;
                o_cmd.mem_re   = 1'b1;
                o_cmd.addr_sel = ADDR_IP2;
                n_state        = S_DEC;
            end
            S_DEC: begin
                o_cmd.latch_a2 = 1'b1;
                n_state        = S_EXEC;
            end
            S_EXEC: begin
                unique case (i_stat.kind)
                    K_JMP: begin
                        o_cmd.mod_start = 1'b1;
                        o_cmd.mod_sel   = MS_A1;
                        n_ret           = S_SETIP;
                        n_state         = S_MOD;
                    end
                    K_RVP: begin
                        o_cmd.mod_start = 1'b1;
                        o_cmd.mod_sel   = MS_A2;
                        n_ret           = S_RVP_RD;
                        n_state         = S_MOD;
                    end
                    K_WVP: begin
                        o_cmd.mod_start = 1'b1;
                        o_cmd.mod_sel   = MS_A1;
                        n_ret           = S_WVP_WR;
                        n_state         = S_MOD;
                    end
                    K_JE, K_JNE: begin
                        if (i_stat.take) begin
                            o_cmd.mem_re   = 1'b1;
                            o_cmd.addr_sel = ADDR_IP3;
                            n_state        = S_TGT;
                        end else begin
                            o_cmd.ip_sel = IP_PLUS4;
                            n_state      = S_FIN;
                        end
                    end
                    default: begin
                        o_cmd.set_halt = 1'b1;
                        n_state        = S_FIN;
                    end
                endcase
            end
            // Reduce the branch target read from the third operand
            S_TGT: begin
                o_cmd.mod_start = 1'b1;
                o_cmd.mod_sel   = MS_RDATA;
                n_ret           = S_SETIP;
                n_state         = S_MOD;
            end
            S_MOD: begin
                if (i_stat.mod_done) begin
                    n_state = r_ret;
                end
            end
            S_SETIP: begin
                o_cmd.ip_sel = IP_MOD;
                n_state      = S_FIN;
            end
            S_RVP_RD: begin
                o_cmd.mem_re   = 1'b1;
                o_cmd.addr_sel = ADDR_MOD;
                n_state        = S_RVP_WR;
            end
            S_RVP_WR: begin
                o_cmd.mem_we   = 1'b1;
                o_cmd.addr_sel = ADDR_IP1;
                o_cmd.wd_sel   = WD_RDATA;
                o_cmd.ip_sel   = IP_PLUS3;
                n_state        = S_FIN;
            end
            S_WVP_WR: begin
                o_cmd.mem_we   = 1'b1;
                o_cmd.addr_sel = ADDR_MOD;
                o_cmd.wd_sel   = WD_A2;
                o_cmd.ip_sel   = IP_PLUS3;
                n_state        = S_FIN;
            end
            S_HWR: begin
                o_cmd.mem_we   = 1'b1;
                o_cmd.addr_sel = ADDR_MOD;
                o_cmd.wd_sel   = WD_HOST;
                n_state        = S_FIN;
            end
            S_HRD: begin
                o_cmd.mem_re   = 1'b1;
                o_cmd.addr_sel = ADDR_MOD;
                n_state        = S_FIN;
            end
            S_RESTART: begin
                o_cmd.ip_sel   = IP_MOD;
                o_cmd.clr_halt = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers; reset starts the memory clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

[rtl/word_memory_jump_machine_core.sv]
// Top level of the word memory jump machine.
//
// Requests enter on start/busy: an item is taken at a clock edge with start
// high and busy low. i_req_type selects write word, read word, execute one
// instruction or restart; i_word_address and i_word_value go with it.
// Each item gives one result on o_read_value, o_pointer_after, o_is_halted
// and o_executed_kind, shown for one cycle with o_done. The receiver cannot
// stall; busy drops in the o_done cycle, so the next item may start there.
// The start address is written on i_cfg_valid/i_cfg_data at any time
// (o_cfg_ready is always high) and takes effect at the next restart.
// Item length depends on its kind. Execute while halted goes straight to the
// result; write, read and restart reduce the address, then access the memory
// or load the pointer; an instruction reads opcode and operands, then halts,
// steps on, or reduces a target or operand address and jumps, stores or copies.
// The single memory port sets this: opcode and operands are read one word a
// cycle. An address reduction keeps the low bits for a power-of-two MEM_DEPTH
// and is serial otherwise (4 remainder bits a cycle). After reset the memory is
// cleared one word a cycle while busy stays high; pointer and halt flag reset to zero.
module word_memory_jump_machine_core import wmjm_pkg::*; #(
    parameter int MEM_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [11:0] i_word_address,
    input  logic [63:0] i_word_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data,
    output logic        o_done,
    output logic [63:0] o_read_value,
    output logic [11:0] o_pointer_after,
    output logic        o_is_halted,
    output logic [2:0]  o_executed_kind
);

    t_cmd  cmd;
    t_stat stat;

    wmjm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    wmjm_dp #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_req_type      (i_req_type),
        .i_word_address  (i_word_address),
        .i_word_value    (i_word_value),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_read_value    (o_read_value),
        .o_pointer_after (o_pointer_after),
        .o_is_halted     (o_is_halted),
        .o_executed_kind (o_executed_kind),
        .o_done          (o_done)
    );

    // Start address register takes writes in every cycle
    assign o_cfg_ready = 1'b1;

endmodule

[rtl/wmjm_chk.sv]
// Port checker for the word memory jump machine, bound to the top level.
module wmjm_chk import wmjm_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [63:0] o_read_value,
    input logic        o_is_halted,
    input logic [2:0]  o_executed_kind
);

    // A result appears only once the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An accepted item occupies the block and gives no result at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted item did not hold the block");

    // A result always follows a busy cycle
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without preceding work");

    // Executed halt leaves the machine halted
    a_halt_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_executed_kind == K_HLT) |-> o_is_halted)
        else $error("halt executed but flag clear");

    // Executed instructions return no read word
    a_exec_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_executed_kind != K_NONE) |-> (o_read_value == 64'd0))
        else $error("read value on an executed instruction");

endmodule

bind word_memory_jump_machine_core wmjm_chk u_chk (.*);
